### src/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared types, reset constants and a helper for the button debounce and
// press stepper.
// ----------------------------------------------------------------------------
package bdp_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_TABLE = 2'd2;

  // Reset values of the registers
  localparam logic [15:0] DEBOUNCE_RST   = 16'd40;
  localparam logic [15:0] LONG_PRESS_RST = 16'd700;
  localparam logic [39:0] DUTY_TABLE_RST = 40'hFF_CC_99_66_33;

  // Default number of brightness steps
  localparam int STEP_COUNT_DEF = 5;

  // Input request
  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_raw;
  } in_item_t;

  // Result
  typedef struct packed {
    logic [7:0] backlight_duty;
    logic [2:0] backlight_step;
    logic       step_advanced;
    logic       long_press_event;
    logic       button_down;
  } out_item_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] long_press_time;
    logic [39:0] duty_table;
  } cfg_t;

  // Pick the duty byte of a step; codes past the table wrap as step mod 5
  function automatic logic [7:0] duty_of(input logic [39:0] tbl, input logic [2:0] step);
    logic [7:0] duty;
    case (step)
      3'd0:    duty = tbl[7:0];
      3'd1:    duty = tbl[15:8];
      3'd2:    duty = tbl[23:16];
      3'd3:    duty = tbl[31:24];
      3'd4:    duty = tbl[39:32];
      3'd5:    duty = tbl[7:0];
      3'd6:    duty = tbl[15:8];
      3'd7:    duty = tbl[23:16];
      default: duty = tbl[7:0];
    endcase
    return duty;
  endfunction

endpackage

### src/bdp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdp_cfg_regs
// Configuration register file: debounce time, long-press time, duty table.
// ----------------------------------------------------------------------------
module bdp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bdp_pkg::cfg_t                  cfg
);

  bdp_pkg::cfg_t cfg_r;
  bdp_pkg::cfg_t cfg_nxt;

  // Decode the write; unknown indexes drop the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bdp_pkg::CFG_DEBOUNCE:   cfg_nxt.debounce_time   = cfg_wdata[15:0];
        bdp_pkg::CFG_LONG_PRESS: cfg_nxt.long_press_time = cfg_wdata[15:0];
        bdp_pkg::CFG_DUTY_TABLE: cfg_nxt.duty_table      = cfg_wdata[39:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= bdp_pkg::DEBOUNCE_RST;
      cfg_r.long_press_time <= bdp_pkg::LONG_PRESS_RST;
      cfg_r.duty_table      <= bdp_pkg::DUTY_TABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/bdp_in_reg.sv
// ----------------------------------------------------------------------------
// bdp_in_reg
// Input register: captures one poll tick request and holds it until the
// press logic takes it.
// ----------------------------------------------------------------------------
module bdp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdp_pkg::in_item_t in_data,
  input  logic              take,
  output logic              item_valid,
  output bdp_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  bdp_pkg::in_item_t item_r;

  // Accept while empty or while the held request leaves this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### src/bdp_press_fsm.sv
// ----------------------------------------------------------------------------
// bdp_press_fsm
// Debounce and press tracking: updates the stable level, press stamp,
// long-press mark and brightness step for one tick, and registers the result.
// ----------------------------------------------------------------------------
module bdp_press_fsm #(
  parameter int STEP_COUNT = bdp_pkg::STEP_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bdp_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  bdp_pkg::in_item_t  item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output bdp_pkg::out_item_t out_data
);

  localparam logic [2:0] STEP_LAST = 3'(STEP_COUNT - 1);

  logic        last_raw_r,     last_raw_nxt;
  logic        stable_r,       stable_nxt;
  logic [31:0] change_stamp_r, change_stamp_nxt;
  logic [31:0] press_stamp_r,  press_stamp_nxt;
  logic        long_r,         long_nxt;
  logic [2:0]  step_r,         step_nxt;
  logic        out_valid_r,    out_valid_nxt;
  bdp_pkg::out_item_t out_data_r, out_data_nxt;

  logic        raw_chg;
  logic [31:0] chg_diff;
  logic        settled;
  logic        upd;
  logic        press;
  logic        release_short;
  logic        long_mid;
  logic [31:0] press_diff;
  logic        long_evt;

  // Advance when the result register is free or drains this cycle
  assign take = item_valid && (!out_valid_r || out_ready);

  // Debounce: a raw change restarts the settle timer at this tick
  always_comb begin
    raw_chg          = item.button_raw != last_raw_r;
    last_raw_nxt     = item.button_raw;
    change_stamp_nxt = raw_chg ? item.now_ms : change_stamp_r;
    chg_diff         = raw_chg ? 32'd0 : (item.now_ms - change_stamp_r);
    settled          = chg_diff >= {16'd0, cfg.debounce_time};
    upd              = settled && (item.button_raw != stable_r);
    stable_nxt       = upd ? item.button_raw : stable_r;
    press            = upd && stable_r;
    release_short    = upd && !stable_r && !long_r;
  end

  // Press stamp, long-press detection and step advance
  always_comb begin
    press_stamp_nxt = press ? item.now_ms : press_stamp_r;
    long_mid        = press ? 1'b0 : long_r;
    press_diff      = press ? 32'd0 : (item.now_ms - press_stamp_r);
    long_evt        = !stable_nxt && !long_mid && (press_diff >= {16'd0, cfg.long_press_time});
    long_nxt        = long_mid || long_evt;
    step_nxt        = step_r;
    if (release_short) begin
      step_nxt = (step_r >= STEP_LAST) ? 3'd0 : step_r + 3'd1;
    end
  end

  // Assemble the result
  always_comb begin
    out_data_nxt.backlight_duty   = bdp_pkg::duty_of(cfg.duty_table, step_nxt);
    out_data_nxt.backlight_step   = step_nxt;
    out_data_nxt.step_advanced    = release_short;
    out_data_nxt.long_press_event = long_evt;
    out_data_nxt.button_down      = !stable_nxt;
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r     <= 1'b1;
      stable_r       <= 1'b1;
      change_stamp_r <= 32'd0;
      press_stamp_r  <= 32'd0;
      long_r         <= 1'b0;
      step_r         <= STEP_LAST;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        last_raw_r     <= last_raw_nxt;
        stable_r       <= stable_nxt;
        change_stamp_r <= change_stamp_nxt;
        press_stamp_r  <= press_stamp_nxt;
        long_r         <= long_nxt;
        step_r         <= step_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/button_debounce_press_stepper_core.sv
// ----------------------------------------------------------------------------
// button_debounce_press_stepper_core
// Debounces an active-low button from timestamped poll ticks, steps the
// backlight on short presses and flags long presses.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_ready  | bdp_pkg::in_item_t
//   out_       | output    | out_valid/out_ready| bdp_pkg::out_item_t
//   cfg_       | input     | cfg_we             | cfg_index, cfg_wdata
//
// One tick request per clock while results drain; a result passes through the
// input register and then the result register around the press logic before
// it shows on out_valid.
// Reset (rst_n low, synchronous) empties both registers and restores state
// and configuration defaults; no clearing pass.
// A stalled result holds in the result register; the input register still
// takes one more request, then in_ready drops until the result drains.
// ----------------------------------------------------------------------------
module button_debounce_press_stepper_core #(
  parameter int STEP_COUNT = bdp_pkg::STEP_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bdp_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bdp_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bdp_pkg::cfg_t     cfg;
  bdp_pkg::in_item_t item;
  logic              item_valid;
  logic              take;

  // Configuration registers
  bdp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  bdp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Press logic and result register
  bdp_press_fsm #(
    .STEP_COUNT (STEP_COUNT)
  ) u_press (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### src/bdp_checker.sv
// ----------------------------------------------------------------------------
// bdp_checker
// Port-level checks of the press stepper results, bound to the top level.
// ----------------------------------------------------------------------------
module bdp_checker #(
  parameter int STEP_COUNT = bdp_pkg::STEP_COUNT_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input bdp_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Keep the step inside the table
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.backlight_step <= 3'(STEP_COUNT - 1))
    else $error("brightness step out of range");

  // Advance only on a release
  a_adv_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_advanced |-> !out_data.button_down)
    else $error("step advanced while button held");

  // Flag a long press only while held
  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.long_press_event |-> out_data.button_down)
    else $error("long press flagged while released");

  // Never both events on one tick
  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.step_advanced && out_data.long_press_event))
    else $error("advance and long press on the same tick");

endmodule

bind button_debounce_press_stepper_core bdp_checker #(
  .STEP_COUNT (STEP_COUNT)
) u_bdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
